// File: hw/rtl/utf8sd_pkg.sv
`timescale 1ns / 1ps

package utf8sd_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_QMARK       = 21'h00003F;
    localparam logic [CP_W-1:0] CP_APOSTROPHE  = 21'h000027;
    localparam logic [CP_W-1:0] CP_QUOTE       = 21'h000022;
    localparam logic [CP_W-1:0] CP_LSQUO       = 21'h002018;
    localparam logic [CP_W-1:0] CP_RSQUO       = 21'h002019;
    localparam logic [CP_W-1:0] CP_LDQUO       = 21'h00201C;
    localparam logic [CP_W-1:0] CP_RDQUO       = 21'h00201D;
    localparam logic [CP_W-1:0] CP_EN_DASH     = 21'h002013;
    localparam logic [CP_W-1:0] CP_EM_DASH     = 21'h002014;

    // what one input byte leaves to emit: a run of '?' then an optional final item
    typedef struct packed {
        logic [1:0]      n_sub;
        logic            has_final;
        logic [CP_W-1:0] final_cp;
        logic            final_sub;
        logic            final_end;
    } job_t;

    function automatic logic [CP_W-1:0] fold_cp(input logic enable, input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] res;
        res = cp;
        if (enable)
        begin
            if (cp == CP_LSQUO || cp == CP_RSQUO)
                res = CP_APOSTROPHE;
            else if (cp == CP_LDQUO || cp == CP_RDQUO)
                res = CP_QUOTE;
            else if (cp == CP_EN_DASH)
                res = CP_EM_DASH;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/utf8sd_decode.sv
`timescale 1ns / 1ps

module utf8sd_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             accept,
    input  logic             cfg_write,
    input  logic             cfg_fold,
    output utf8sd_pkg::job_t job
);
    import utf8sd_pkg::*;

    logic            fold_reg;
    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      expected_reg, expected_next;
    logic [1:0]      seen_reg, seen_next;

    logic            is_cont;
    logic [CP_W-1:0] cont_acc;
    logic [1:0]      cont_seen;

    assign is_cont   = (in_byte[7:6] == 2'b10);
    assign cont_acc  = {acc_reg[CP_W-7:0], in_byte[5:0]};
    assign cont_seen = seen_reg + 2'd1;

    always_comb
    begin
        acc_next      = acc_reg;
        expected_next = expected_reg;
        seen_next     = seen_reg;
        job           = '0;

        if (expected_reg != 2'd0 && is_cont)
        begin
            if (cont_seen >= expected_reg)
            begin
                job.has_final = 1'b1;
                job.final_cp  = fold_cp(fold_reg, cont_acc);
                acc_next      = '0;
                expected_next = 2'd0;
                seen_next     = 2'd0;
            end
            else
            begin
                acc_next  = cont_acc;
                seen_next = cont_seen;
            end
        end
        else
        begin
            // broken sequence: one '?' for the lead, one per buffered continuation
            if (expected_reg != 2'd0)
                job.n_sub = (seen_reg >= 2'd2) ? 2'd3 : seen_reg + 2'd1;
            acc_next      = '0;
            expected_next = 2'd0;
            seen_next     = 2'd0;

            if (in_byte == 8'h00)
            begin
                job.has_final = 1'b1;
                job.final_end = 1'b1;
            end
            else if (in_byte[7] == 1'b0)
            begin
                job.has_final = 1'b1;
                job.final_cp  = fold_cp(fold_reg, {{(CP_W-8){1'b0}}, in_byte});
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                acc_next      = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                expected_next = 2'd1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                acc_next      = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                expected_next = 2'd2;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                acc_next      = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                expected_next = 2'd3;
            end
            else
            begin
                job.has_final = 1'b1;
                job.final_cp  = CP_QMARK;
                job.final_sub = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg     <= 1'b1;
            acc_reg      <= '0;
            expected_reg <= 2'd0;
            seen_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_write)
                fold_reg <= cfg_fold;
            if (accept)
            begin
                acc_reg      <= acc_next;
                expected_reg <= expected_next;
                seen_reg     <= seen_next;
            end
        end
    end

endmodule

// File: hw/rtl/utf8sd_emit.sv
`timescale 1ns / 1ps

module utf8sd_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  utf8sd_pkg::job_t job_in,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [20:0]      out_cp,
    output logic             out_sub,
    output logic             out_end,
    output logic             out_last
);
    import utf8sd_pkg::*;

    job_t       job_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;

    logic [2:0] total;
    logic       in_sub_run;
    logic       has_items;

    assign total      = {1'b0, job_reg.n_sub} + {2'b00, job_reg.has_final};
    assign in_sub_run = (idx_reg < job_reg.n_sub);
    assign out_last   = ({1'b0, idx_reg} == total - 3'd1);
    assign has_items  = (job_in.n_sub != 2'd0) || job_in.has_final;

    assign out_valid = valid_reg;
    assign out_cp    = in_sub_run ? CP_QMARK : job_reg.final_cp;
    assign out_sub   = in_sub_run ? 1'b1 : job_reg.final_sub;
    assign out_end   = in_sub_run ? 1'b0 : job_reg.final_end;

    // a new word may enter in the same cycle the final item of the current run leaves
    assign free = !valid_reg || (out_ready && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= has_items;
            idx_reg   <= 2'd0;
        end
        else if (valid_reg && out_ready)
        begin
            if (out_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job_in;
    end

endmodule

// File: hw/rtl/utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// utf8 stream decoder
// s_axis carries one raw byte per word; a zero byte ends a string.
// m_axis carries one decoded item per word: the code point in tdata, the
// substitution and end-of-string flags in tuser, and tlast on the final item
// caused by an input byte. bytes that only start or extend a sequence give no item.
// the byte is decoded in the cycle it is accepted; its items appear on m_axis
// from the next cycle. throughput: one byte per cycle while m_axis_tready is high
// and every byte gives at most one item.
// a byte that breaks a sequence gives up to four items, emitted one per cycle
// from the job register, and s_axis_tready stays low until the last one leaves.
// when m_axis_tready is low the current item holds and s_axis stalls once the
// job register is full.
// cfg: cfg_data[0] sets punctuation folding, always ready; write it while idle.
// reset: decoder idle, no item pending, folding on.
module utf8_stream_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [0] substituted, [1] string_end
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import utf8sd_pkg::*;

    job_t        job;
    logic        accept;
    logic        free;
    logic [20:0] cp;

    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;
    assign cfg_ready     = 1'b1;

    utf8sd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_axis_tdata),
        .accept    (accept),
        .cfg_write (cfg_valid),
        .cfg_fold  (cfg_data),
        .job       (job)
    );

    utf8sd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .job_in    (job),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_cp    (cp),
        .out_sub   (m_axis_tuser[0]),
        .out_end   (m_axis_tuser[1]),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, cp};

endmodule

// File: hw/rtl/utf8sd_checker.sv
`timescale 1ns / 1ps

module utf8sd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // input only stalls behind pending output
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with nothing pending");

    a_sub: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'h00003F && !m_axis_tuser[1])
        else $error("substitution word is not a question mark");

    // end of string is always the final item of its byte
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 24'h000000 && m_axis_tlast)
        else $error("malformed end-of-string word");

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/utf8_stream_decoder_top_test.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_top_test;

    import utf8sd_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            sub;
        logic            eos;
        logic            last;
    } cp_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    // decoder state as the predictor sees it
    logic [CP_W-1:0] acc_value = '0;
    logic [1:0]      conts_needed = 2'd0;
    logic [1:0]      conts_seen = 2'd0;
    logic            fold_on = 1'b1;

    cp_item_t   decoded_due[$];
    logic [7:0] text_bytes[$];
    int         mismatches = 0;
    int         bytes_sent = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         stall_target = 0;
    int         stall_done = 0;

    utf8_stream_decoder_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [CP_W-1:0] fold_punct(input logic [CP_W-1:0] cp);
        if (!fold_on)
            return cp;
        case (cp)
            CP_LSQUO, CP_RSQUO: return CP_APOSTROPHE;
            CP_LDQUO, CP_RDQUO: return CP_QUOTE;
            CP_EN_DASH:         return CP_EM_DASH;
            default:            return cp;
        endcase
    endfunction

    // works out every item one accepted byte gives
    task automatic decode_byte(input logic [7:0] b);
        cp_item_t run[$];
        logic     relead;
        relead = 1'b1;
        if (conts_needed != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                relead = 1'b0;
                acc_value = {acc_value[CP_W-7:0], b[5:0]};
                conts_seen = conts_seen + 2'd1;
                if (conts_seen >= conts_needed)
                begin
                    run.push_back('{fold_punct(acc_value), 1'b0, 1'b0, 1'b0});
                    acc_value = '0;
                    conts_needed = 2'd0;
                    conts_seen = 2'd0;
                end
            end
            else
            begin
                // broken sequence: '?' for the lead and each buffered continuation
                run.push_back('{CP_QMARK, 1'b1, 1'b0, 1'b0});
                for (int k = 0; k < conts_seen && k < 2; k++)
                    run.push_back('{CP_QMARK, 1'b1, 1'b0, 1'b0});
                acc_value = '0;
                conts_needed = 2'd0;
                conts_seen = 2'd0;
            end
        end
        if (relead)
        begin
            if (b == 8'h00)
                run.push_back('{'0, 1'b0, 1'b1, 1'b0});
            else if (!b[7])
                run.push_back('{fold_punct({13'd0, b}), 1'b0, 1'b0, 1'b0});
            else if (b[7:5] == 3'b110)
            begin
                acc_value = {16'd0, b[4:0]};
                conts_needed = 2'd1;
                conts_seen = 2'd0;
            end
            else if (b[7:4] == 4'b1110)
            begin
                acc_value = {17'd0, b[3:0]};
                conts_needed = 2'd2;
                conts_seen = 2'd0;
            end
            else if (b[7:3] == 5'b11110)
            begin
                acc_value = {18'd0, b[2:0]};
                conts_needed = 2'd3;
                conts_seen = 2'd0;
            end
            else
                run.push_back('{CP_QMARK, 1'b1, 1'b0, 1'b0});
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            decoded_due.push_back(run[i]);
    endtask

    always @(posedge clk)
    begin
        if (stall_done < stall_target)
        begin
            m_axis_tready <= 1'b0;
            stall_done <= stall_done + 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cp_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (decoded_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word cp=%h user=%b last=%b", $time,
                         m_axis_tdata[CP_W-1:0], m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = decoded_due.pop_front();
                if (m_axis_tdata[CP_W-1:0] !== want.cp || m_axis_tuser[0] !== want.sub ||
                    m_axis_tuser[1] !== want.eos || m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    $display("%0t: mismatch expected cp=%h sub=%b end=%b last=%b", $time,
                             want.cp, want.sub, want.eos, want.last);
                    $display("%0t:          actual   cp=%h sub=%b end=%b last=%b", $time,
                             m_axis_tdata[CP_W-1:0], m_axis_tuser[0], m_axis_tuser[1],
                             m_axis_tlast);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text();
        while (text_bytes.size() > 0)
            send_byte(text_bytes.pop_front());
    endtask

    task automatic add_char(input int len, input logic [CP_W-1:0] cp);
        case (len)
            1: text_bytes.push_back({1'b0, cp[6:0]});
            2:
            begin
                text_bytes.push_back({3'b110, cp[10:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                text_bytes.push_back({4'b1110, cp[15:12]});
                text_bytes.push_back({2'b10, cp[11:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                text_bytes.push_back({5'b11110, cp[20:18]});
                text_bytes.push_back({2'b10, cp[17:12]});
                text_bytes.push_back({2'b10, cp[11:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        // a lead byte gives nothing, so let the pipe settle
        repeat (4) @(posedge clk);
    endtask

    task automatic write_fold(input logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        fold_on = v;
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed characters, some broken sequences, stray bytes and zeros
    task automatic send_random_text(input int n_bytes);
        logic [CP_W-1:0] punct[6];
        int              stop_at;
        int              pick;
        int              len;
        int              keep;
        int              r;
        logic [CP_W-1:0] cp;
        punct = '{CP_LSQUO, CP_RSQUO, CP_LDQUO, CP_RDQUO, CP_EN_DASH, CP_EM_DASH};
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            len = $urandom_range(1, 4);
            cp = CP_W'($urandom());
            if (len == 1)
                cp = CP_W'($urandom_range(1, 127));
            else if (len == 3 && $urandom_range(4) == 0)
                cp = punct[$urandom_range(5)];
            if (pick < 70)
                add_char(len, cp);
            else if (pick < 76)
                text_bytes.push_back(8'h00);
            else if (pick < 90)
            begin
                len = $urandom_range(2, 4);
                add_char(len, cp);
                keep = $urandom_range(0, len - 2);
                repeat (len - 1 - keep) void'(text_bytes.pop_back());
                r = $urandom_range(191);
                text_bytes.push_back((r < 128) ? 8'(r) : 8'(r + 64));
            end
            else
                text_bytes.push_back(8'($urandom_range(255)));
            send_text();
        end
    endtask

    task automatic test_directed();
        logic [7:0] seq[];
        seq = '{8'h41, 8'h00, 8'hC2, 8'hA9, 8'hE2, 8'h80, 8'h98, 8'hE2, 8'h80, 8'h93,
                8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hE2, 8'h80, 8'h41,
                8'hF0, 8'h80, 8'h80, 8'h00};
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        foreach (seq[i])
            send_byte(seq[i]);
        wait_drain();
    endtask

    task automatic test_fold_off();
        write_fold(1'b0);
        add_char(3, CP_LSQUO);
        add_char(3, CP_RDQUO);
        add_char(3, CP_EN_DASH);
        add_char(1, 21'h22);
        send_text();
        wait_drain();
        write_fold(1'b1);
    endtask

    task automatic test_random_phases();
        tx_idle_pct = 25;
        rx_idle_pct = 65;
        send_random_text(100);
        wait_drain();
        write_fold(1'b0);
        tx_idle_pct = 65;
        rx_idle_pct = 25;
        send_random_text(100);
        wait_drain();
        write_fold(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_text(100);
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long hold on the output side while bytes keep coming
        stall_target <= stall_target + 300;
        send_random_text(40);
        wait_drain();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fold_off();
        test_random_phases();
        test_backpressure();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && decoded_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_decode.sv
hw/rtl/utf8sd_emit.sv
hw/rtl/utf8_stream_decoder_top.sv
hw/rtl/utf8sd_checker.sv
tb/utf8_stream_decoder_top_test.sv
